// ===== design/screen_cell_text_encoder_defines.svh =====
// Assertion macros shared by the checker of the screen cell text encoder.
// Depends on nothing; the using module provides aclk and aresetn.
`ifndef SCREEN_CELL_TEXT_ENCODER_DEFINES_SVH
`define SCREEN_CELL_TEXT_ENCODER_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define SCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also watches the reset itself
`define SCE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/sce_pkg.sv =====
// Package of the screen cell text encoder: codes, byte constants and the
// configuration and command structs passed between front, queue and back.
`timescale 1ns / 1ps

package sce_pkg;

    typedef enum logic [1:0] {
        KC_NONE = 2'd0,
        KC_EUC  = 2'd1,
        KC_JIS  = 2'd2,
        KC_SJIS = 2'd3
    } kanji_code_t;

    typedef enum logic [1:0] {
        SH_ASCII = 2'd0,
        SH_KANJI = 2'd1,
        SH_KANA  = 2'd2
    } shift_mode_t;

    typedef enum logic [1:0] {
        CFG_KANJI_CODE      = 2'd0,
        CFG_KANJI_SELECT    = 2'd1,
        CFG_ASCII_SELECT    = 2'd2,
        CFG_KEEP_RENDITIONS = 2'd3
    } cfg_index_t;

    // Output segments of one transaction, emitted in this order
    typedef enum logic [2:0] {
        SEG_REND_OFF  = 3'd0,
        SEG_REV_ON    = 3'd1,
        SEG_UL_ON     = 3'd2,
        SEG_SHIFT     = 3'd3,
        SEG_CLOSE_OFF = 3'd4,
        SEG_CHAR0     = 3'd5,
        SEG_CHAR1     = 3'd6
    } seg_t;

    localparam int NUM_SEGS = 7;

    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_M        = 8'h6d;
    localparam logic [7:0] CH_SEVEN    = 8'h37;
    localparam logic [7:0] CH_FOUR     = 8'h34;
    localparam logic [7:0] CH_KANA_SEL = 8'h49;
    localparam logic [7:0] CH_NEWLINE  = 8'h0a;
    localparam logic [7:0] CH_PLUS     = 8'h2b;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_BAR      = 8'h7c;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QMARK    = 8'h3f;
    localparam logic [7:0] EUC_SS2     = 8'h8e;

    typedef struct packed {
        kanji_code_t kanji_code;
        logic [7:0]  kanji_select;
        logic [7:0]  ascii_select;
        logic        keep_renditions;
    } cfg_t;

    typedef struct packed {
        logic [NUM_SEGS-1:0] seg_mask;
        logic [7:0]          esc_b2;
        logic [7:0]          esc_b3;
        logic [7:0]          char0;
        logic [7:0]          char1;
    } cmd_t;

endpackage

// ===== design/sce_front.sv =====
// Front of the screen cell text encoder: classifies each cell, keeps the
// shift and rendition state and builds a compact command. Uses sce_pkg.
`timescale 1ns / 1ps

module sce_front import sce_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        accept,
    input  logic        op,
    input  logic [15:0] char_code,
    input  logic        is_graphic,
    input  logic        is_kanji_lead,
    input  logic        is_kanji_trail,
    input  logic        reverse,
    input  logic        underline,
    output cmd_t        cmd
);

    shift_mode_t shift_mode_reg, shift_mode_next;
    logic        reverse_on_reg, reverse_on_next;
    logic        underline_on_reg, underline_on_next;

    // Map a line drawing character to plain ASCII
    function automatic logic [7:0] graphic_map(input logic [15:0] c);
        logic [7:0] r;
        r = CH_QMARK;
        if (c[15:8] == 8'h00) begin
            unique case (c[7:0])
                8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e,
                8'h74, 8'h75, 8'h76, 8'h77: r = CH_PLUS;
                8'h71:                      r = CH_MINUS;
                8'h78:                      r = CH_BAR;
                8'h20:                      r = CH_SPACE;
                default:                    r = CH_QMARK;
            endcase
        end
        return r;
    endfunction

    // Build the command and the next state
    always_comb begin
        cmd               = '0;
        shift_mode_next   = shift_mode_reg;
        reverse_on_next   = reverse_on_reg;
        underline_on_next = underline_on_reg;

        if (op) begin
            // end of line: close shift, reset renditions, newline
            if (shift_mode_reg != SH_ASCII) begin
                cmd.seg_mask[SEG_SHIFT] = 1'b1;
                cmd.esc_b2              = CH_LPAREN;
                cmd.esc_b3              = cfg.ascii_select;
            end
            if (cfg.keep_renditions && (reverse_on_reg || underline_on_reg)) begin
                cmd.seg_mask[SEG_CLOSE_OFF] = 1'b1;
            end
            cmd.seg_mask[SEG_CHAR0] = 1'b1;
            cmd.char0               = CH_NEWLINE;
            shift_mode_next         = SH_ASCII;
            reverse_on_next         = 1'b0;
            underline_on_next       = 1'b0;
        end else begin
            if (cfg.keep_renditions) begin
                cmd.seg_mask[SEG_REND_OFF] = (reverse_on_reg && !reverse) ||
                                             (underline_on_reg && !underline);
                cmd.seg_mask[SEG_REV_ON]   = !reverse_on_reg && reverse;
                cmd.seg_mask[SEG_UL_ON]    = !underline_on_reg && underline;
                reverse_on_next            = reverse;
                underline_on_next          = underline;
            end

            priority if (is_graphic) begin
                if (cfg.kanji_code == KC_JIS && shift_mode_reg != SH_ASCII) begin
                    cmd.seg_mask[SEG_SHIFT] = 1'b1;
                    cmd.esc_b2              = CH_LPAREN;
                    cmd.esc_b3              = cfg.ascii_select;
                    shift_mode_next         = SH_ASCII;
                end
                cmd.seg_mask[SEG_CHAR0] = 1'b1;
                cmd.char0               = graphic_map(char_code);
            end else if (is_kanji_lead) begin
                cmd.seg_mask[SEG_CHAR0] = 1'b1;
                cmd.seg_mask[SEG_CHAR1] = 1'b1;
                unique case (cfg.kanji_code)
                    KC_JIS: begin
                        if (shift_mode_reg != SH_KANJI) begin
                            cmd.seg_mask[SEG_SHIFT] = 1'b1;
                            cmd.esc_b2              = CH_DOLLAR;
                            cmd.esc_b3              = cfg.kanji_select;
                            shift_mode_next         = SH_KANJI;
                        end
                        cmd.char0 = {1'b0, char_code[14:8]};
                        cmd.char1 = {1'b0, char_code[6:0]};
                    end
                    KC_SJIS: begin
                        cmd.char0 = char_code[15:8];
                        cmd.char1 = char_code[7:0];
                    end
                    default: begin
                        cmd.char0 = {1'b1, char_code[14:8]};
                        cmd.char1 = {1'b1, char_code[6:0]};
                    end
                endcase
            end else if (is_kanji_trail) begin
                // second half of a kanji: no character bytes
                cmd.char0 = '0;
            end else if (char_code[7]) begin
                unique case (cfg.kanji_code)
                    KC_JIS: begin
                        if (shift_mode_reg != SH_KANA) begin
                            cmd.seg_mask[SEG_SHIFT] = 1'b1;
                            cmd.esc_b2              = CH_LPAREN;
                            cmd.esc_b3              = CH_KANA_SEL;
                            shift_mode_next         = SH_KANA;
                        end
                        cmd.seg_mask[SEG_CHAR0] = 1'b1;
                        cmd.char0               = {1'b0, char_code[6:0]};
                    end
                    KC_SJIS: begin
                        cmd.seg_mask[SEG_CHAR0] = 1'b1;
                        cmd.char0               = char_code[7:0];
                    end
                    default: begin
                        cmd.seg_mask[SEG_CHAR0] = 1'b1;
                        cmd.seg_mask[SEG_CHAR1] = 1'b1;
                        cmd.char0               = EUC_SS2;
                        cmd.char1               = char_code[7:0];
                    end
                endcase
            end else begin
                if (cfg.kanji_code == KC_JIS && shift_mode_reg != SH_ASCII) begin
                    cmd.seg_mask[SEG_SHIFT] = 1'b1;
                    cmd.esc_b2              = CH_LPAREN;
                    cmd.esc_b3              = cfg.ascii_select;
                    shift_mode_next         = SH_ASCII;
                end
                cmd.seg_mask[SEG_CHAR0] = 1'b1;
                cmd.char0               = {1'b0, char_code[6:0]};
            end
        end
    end

    // Advance the state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_mode_reg   <= SH_ASCII;
            reverse_on_reg   <= 1'b0;
            underline_on_reg <= 1'b0;
        end else if (accept) begin
            shift_mode_reg   <= shift_mode_next;
            reverse_on_reg   <= reverse_on_next;
            underline_on_reg <= underline_on_next;
        end
    end

endmodule

// ===== design/sce_queue.sv =====
// Command queue between front and back of the screen cell text encoder.
// A small circular buffer of cmd_t entries; uses sce_pkg.
`timescale 1ns / 1ps

module sce_queue import sce_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t head,
    output logic not_empty,
    output logic not_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign head      = mem_reg[rd_ptr_reg];

    // Wrap pointers and track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries; payload needs no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/sce_back.sv =====
// Back of the screen cell text encoder: expands one command into bytes,
// one per cycle unless m_ready stalls, into a registered output stage. Uses sce_pkg.
`timescale 1ns / 1ps

module sce_back import sce_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head,
    input  logic       q_not_empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    logic [NUM_SEGS-1:0] mask_reg, mask_next;
    cmd_t                work_reg, work_next;
    logic [1:0]          sub_reg, sub_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;

    seg_t                cur_seg;
    logic [NUM_SEGS-1:0] rest_mask;
    logic [1:0]          seg_last_sub;
    logic [7:0]          cur_byte;
    logic                busy;
    logic                seg_end;
    logic                item_end;
    logic                load_out;
    logic                emit;

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = out_last_reg;

    // Pick the lowest pending segment
    always_comb begin
        priority if (mask_reg[SEG_REND_OFF])  cur_seg = SEG_REND_OFF;
        else if (mask_reg[SEG_REV_ON])        cur_seg = SEG_REV_ON;
        else if (mask_reg[SEG_UL_ON])         cur_seg = SEG_UL_ON;
        else if (mask_reg[SEG_SHIFT])         cur_seg = SEG_SHIFT;
        else if (mask_reg[SEG_CLOSE_OFF])     cur_seg = SEG_CLOSE_OFF;
        else if (mask_reg[SEG_CHAR0])         cur_seg = SEG_CHAR0;
        else                                  cur_seg = SEG_CHAR1;
    end

    // Select the byte of the current segment
    always_comb begin
        rest_mask          = mask_reg;
        rest_mask[cur_seg] = 1'b0;
        seg_last_sub       = 2'd0;
        cur_byte           = CH_ESC;
        unique case (cur_seg)
            SEG_REND_OFF, SEG_CLOSE_OFF: begin
                seg_last_sub = 2'd2;
                unique case (sub_reg)
                    2'd0:    cur_byte = CH_ESC;
                    2'd1:    cur_byte = CH_LBRACKET;
                    default: cur_byte = CH_M;
                endcase
            end
            SEG_REV_ON, SEG_UL_ON: begin
                seg_last_sub = 2'd3;
                unique case (sub_reg)
                    2'd0:    cur_byte = CH_ESC;
                    2'd1:    cur_byte = CH_LBRACKET;
                    2'd2:    cur_byte = (cur_seg == SEG_REV_ON) ? CH_SEVEN : CH_FOUR;
                    default: cur_byte = CH_M;
                endcase
            end
            SEG_SHIFT: begin
                seg_last_sub = 2'd2;
                unique case (sub_reg)
                    2'd0:    cur_byte = CH_ESC;
                    2'd1:    cur_byte = work_reg.esc_b2;
                    default: cur_byte = work_reg.esc_b3;
                endcase
            end
            SEG_CHAR0: cur_byte = work_reg.char0;
            SEG_CHAR1: cur_byte = work_reg.char1;
            default:   cur_byte = work_reg.char1;
        endcase
    end

    // Sequence bytes and fetch the next command without a bubble
    always_comb begin
        busy     = (mask_reg != '0);
        seg_end  = (sub_reg == seg_last_sub);
        item_end = seg_end && (rest_mask == '0);
        load_out = !out_valid_reg || m_ready;
        emit     = load_out && busy;
        pop      = q_not_empty && (!busy || (emit && item_end));

        mask_next      = mask_reg;
        work_next      = work_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = item_end;
            if (seg_end) begin
                mask_next = rest_mask;
                sub_next  = 2'd0;
            end else begin
                sub_next = sub_reg + 2'd1;
            end
        end else if (load_out) begin
            out_valid_next = 1'b0;
        end

        if (pop) begin
            mask_next = head.seg_mask;
            work_next = head;
            sub_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            mask_reg      <= mask_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload; no reset needed
    always_ff @(posedge aclk) begin
        work_reg     <= work_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== design/screen_cell_text_encoder.sv =====
// Throughput: one output byte per cycle unless m_ready stalls it; a transaction
// causes 0 to 13 bytes, the byte sequencer in sce_back being the limit.
// Path: queue, then the sce_back work registers, then the output register;
// the queue lets the input run ahead.
// Reset (aresetn low, synchronous): clears shift and rendition state, empties
// the queue and the output stage, and restores the configuration defaults.
`timescale 1ns / 1ps

module screen_cell_text_encoder import sce_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_char_code,
    input  logic        s_is_graphic,
    input  logic        s_is_kanji_lead,
    input  logic        s_is_kanji_trail,
    input  logic        s_reverse,
    input  logic        s_underline,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    cfg_t cfg_reg, cfg_next;
    cmd_t front_cmd;
    cmd_t q_head;
    logic accept;
    logic push;
    logic pop;
    logic q_not_empty;
    logic q_not_full;

    assign s_ready = q_not_full;
    assign accept  = s_valid && s_ready;
    // drop transactions that cause no bytes
    assign push    = accept && (front_cmd.seg_mask != '0);

    // Configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KANJI_CODE:      cfg_next.kanji_code      = kanji_code_t'(cfg_wdata[1:0]);
                CFG_KANJI_SELECT:    cfg_next.kanji_select    = cfg_wdata;
                CFG_ASCII_SELECT:    cfg_next.ascii_select    = cfg_wdata;
                CFG_KEEP_RENDITIONS: cfg_next.keep_renditions = cfg_wdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kanji_code      <= KC_NONE;
            cfg_reg.kanji_select    <= 8'd66;
            cfg_reg.ascii_select    <= 8'd66;
            cfg_reg.keep_renditions <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sce_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .accept         (accept),
        .op             (s_op),
        .char_code      (s_char_code),
        .is_graphic     (s_is_graphic),
        .is_kanji_lead  (s_is_kanji_lead),
        .is_kanji_trail (s_is_kanji_trail),
        .reverse        (s_reverse),
        .underline      (s_underline),
        .cmd            (front_cmd)
    );

    sce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    sce_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (q_head),
        .q_not_empty (q_not_empty),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last)
    );

endmodule

// ===== design/sce_checker.sv =====
// Port level checker for the screen cell text encoder, bound to the top level.
// Depends on screen_cell_text_encoder_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "screen_cell_text_encoder_defines.svh"

module sce_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last
);

    // Hold a stalled result transaction
    `SCE_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last), "result changed while stalled")

    // Bytes of one input transaction leave without gaps
    `SCE_ASSERT(a_no_gap, m_valid && m_ready && !m_last |=> m_valid, "gap inside a byte sequence")

    // The queue fills only by accepting input
    `SCE_ASSERT(a_ready_fall, $fell(s_ready) |-> $past(s_valid), "ready dropped without input")

    // Reset empties the output stage
    `SCE_ASSERT_RST(a_reset_out, !aresetn |=> !m_valid, "output valid after reset")

endmodule

bind screen_cell_text_encoder sce_checker u_sce_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_last     (m_last)
);
